[hw/rtl/fshd_pkg.sv]
package fshd_pkg;

  // Default build values
  localparam int MAX_HOLD_DEF    = 64;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int FRAC_BITS_DEF   = 16;

  // Register widths fixed by the register map
  localparam int HF_BITS       = 7;
  localparam int CFG_IDX_BITS  = 2;
  localparam logic [HF_BITS-1:0] HOLD_FACTOR_RST = HF_BITS'(1);

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_FACTOR = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLD_FRAC   = CFG_IDX_BITS'(1);

endpackage

[hw/rtl/fshd_core.sv]
module fshd_core #(
  parameter int MAX_HOLD    = fshd_pkg::MAX_HOLD_DEF,
  parameter int SAMPLE_BITS = fshd_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = fshd_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                en_i,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic                                start_i,
  input  logic [fshd_pkg::HF_BITS-1:0]        hold_factor_i,
  input  logic [FRAC_BITS-1:0]                hold_frac_i,
  output logic signed [SAMPLE_BITS-1:0]       result_o
);
  import fshd_pkg::*;

  localparam int PSW = (MAX_HOLD > 1) ? $clog2(MAX_HOLD) : 1;
  localparam int PLW = $clog2(MAX_HOLD + 1);
  localparam int NW  = $clog2(MAX_HOLD + 2);
  localparam int CW  = (NW > HF_BITS) ? NW : HF_BITS;
  localparam int PW  = SAMPLE_BITS + FRAC_BITS + 2;

  logic [PSW-1:0] phase_short_q, phase_short_d;
  logic [PLW-1:0] phase_long_q, phase_long_d;
  logic signed [SAMPLE_BITS-1:0] held_short_q, held_long_q;

  logic [CW-1:0] hf_ext, max_ext, n_c;
  logic [NW-1:0] n, l, ps_inc, pl_inc;
  logic [PSW-1:0] ps;
  logic [PLW-1:0] pl;
  logic edge_s, edge_l;
  logic signed [SAMPLE_BITS-1:0] y1, y2;
  logic signed [SAMPLE_BITS:0] diff;
  logic signed [PW-1:0] diff_x, frac_x, prod, shifted;

  always_comb begin
    hf_ext  = CW'(hold_factor_i);
    max_ext = CW'(MAX_HOLD);
    n_c     = (hf_ext > max_ext) ? max_ext : hf_ext;
    n       = NW'(n_c);
    l       = n + NW'(1);

    // block start restarts both phases before this word is used
    ps = start_i ? '0 : phase_short_q;
    pl = start_i ? '0 : phase_long_q;

    edge_s = (n > NW'(1)) && (ps == '0);
    edge_l = (l > NW'(1)) && (pl == '0);

    y1 = ((n <= NW'(1)) || edge_s) ? sample_i : held_short_q;
    y2 = ((l <= NW'(1)) || edge_l) ? sample_i : held_long_q;

    diff    = {y2[SAMPLE_BITS-1], y2} - {y1[SAMPLE_BITS-1], y1};
    diff_x  = {{(FRAC_BITS + 1){diff[SAMPLE_BITS]}}, diff};
    frac_x  = {{(SAMPLE_BITS + 2){1'b0}}, hold_frac_i};
    prod    = diff_x * frac_x;
    shifted = prod >>> FRAC_BITS;   // floor toward minus infinity
    // blend lies between y1 and y2, so the low bits carry the full result
    result_o = y1 + $signed(shifted[SAMPLE_BITS-1:0]);

    ps_inc = NW'(ps) + NW'(1);
    pl_inc = NW'(pl) + NW'(1);
    phase_short_d = ((n <= NW'(1)) || (ps_inc >= n)) ? '0 : PSW'(ps_inc);
    phase_long_d  = ((l <= NW'(1)) || (pl_inc >= l)) ? '0 : PLW'(pl_inc);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_short_q <= '0;
      phase_long_q  <= '0;
      held_short_q  <= '0;
      held_long_q   <= '0;
    end else if (en_i) begin
      phase_short_q <= phase_short_d;
      phase_long_q  <= phase_long_d;
      // a stage holds the blended output, not the raw input
      if (edge_s) begin
        held_short_q <= result_o;
      end
      if (edge_l) begin
        held_long_q <= result_o;
      end
    end
  end

endmodule

[hw/rtl/fractional_sample_hold_downsampler_unit.sv]
// Fractional sample-and-hold downsampler. Takes one Q1.23 word per cycle while
// the output is not stalled and returns one word per input. The input register
// holds the accepted word, and the phase counters, hold muxes and one blend
// multiply feed the result register. The result is valid once the staged word
// advances into the result register. With the output drained, a new word is
// taken every clock; the combinational path through the blend multiplier sets
// the clock period. hold_factor and hold_frac take effect on the next word;
// write them only while no word is in flight.
module fractional_sample_hold_downsampler_unit #(
  parameter int MAX_HOLD    = fshd_pkg::MAX_HOLD_DEF,
  parameter int SAMPLE_BITS = fshd_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = fshd_pkg::FRAC_BITS_DEF,
  parameter int CFG_DW      = (FRAC_BITS > fshd_pkg::HF_BITS) ? FRAC_BITS : fshd_pkg::HF_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [fshd_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [CFG_DW-1:0]                     cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]         sample_in_i,
  input  logic                                  block_start_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]         sample_out_o
);
  import fshd_pkg::*;

  logic [HF_BITS-1:0]   hold_factor_q;
  logic [FRAC_BITS-1:0] hold_frac_q;

  logic                          s1_valid_q;
  logic signed [SAMPLE_BITS-1:0] s1_sample_q;
  logic                          s1_start_q;
  logic                          advance;
  logic signed [SAMPLE_BITS-1:0] result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_factor_q <= HOLD_FACTOR_RST;
      hold_frac_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_HOLD_FACTOR: hold_factor_q <= cfg_data_i[HF_BITS-1:0];
        REG_HOLD_FRAC:   hold_frac_q   <= cfg_data_i[FRAC_BITS-1:0];
        default: ;
      endcase
    end
  end

  // stage word moves on when the result register is free or being drained
  assign advance    = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_sample_q <= sample_in_i;
      s1_start_q  <= block_start_i;
    end
  end

  fshd_core #(
    .MAX_HOLD    (MAX_HOLD),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (advance),
    .sample_i      (s1_sample_q),
    .start_i       (s1_start_q),
    .hold_factor_i (hold_factor_q),
    .hold_frac_i   (hold_frac_q),
    .result_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (advance) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      sample_out_o <= result;
    end
  end

  a_stage_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_o) |=> out_valid_o)
    else $error("staged word did not reach the result register");

  a_accept_full_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && s1_valid_q) |-> advance)
    else $error("word accepted over a stalled stage");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (out_valid_o && (sample_out_o == $past(result))))
    else $error("result register not loaded on advance");

endmodule

[bench/fshd_hold_checker.sv]
module fshd_hold_checker #(
  parameter int CFG_DW = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_valid_i,
  input  logic                                        cfg_ready_i,
  input  logic [fshd_pkg::CFG_IDX_BITS-1:0]           cfg_index_i,
  input  logic [CFG_DW-1:0]                           cfg_data_i,
  input  logic                                        in_valid_i,
  input  logic                                        in_ready_i,
  input  logic signed [fshd_pkg::SAMPLE_BITS_DEF-1:0] sample_in_i,
  input  logic                                        block_start_i,
  input  logic                                        out_valid_i,
  input  logic                                        out_ready_i,
  input  logic signed [fshd_pkg::SAMPLE_BITS_DEF-1:0] sample_out_i,
  output int                                          error_count,
  output int                                          pending_words,
  output int                                          checked_words
);
  import fshd_pkg::*;

  localparam int SW = SAMPLE_BITS_DEF;
  localparam int FW = FRAC_BITS_DEF;

  // shadow of the hold registers
  logic [HF_BITS-1:0] factor_q = HOLD_FACTOR_RST;
  logic [FW-1:0]      frac_q   = '0;

  int                 short_phase = 0;
  int                 long_phase  = 0;
  logic signed [SW-1:0] short_held = '0;
  logic signed [SW-1:0] long_held  = '0;

  logic signed [SW-1:0] held_samples_due[$];
  int                   mismatches = 0;
  int                   seen       = 0;

  // Next output of the two hold stages blended by the fraction. Each stage
  // latches the blended result at its boundary, not the raw input.
  function automatic logic signed [SW-1:0] hold_and_blend(logic signed [SW-1:0] x,
                                                          logic start);
    int     n;
    int     l;
    bit     take_s;
    bit     take_l;
    longint y1;
    longint y2;
    longint blended;
    n = (factor_q > MAX_HOLD_DEF) ? MAX_HOLD_DEF : int'(factor_q);
    l = n + 1;
    if (start) begin
      short_phase = 0;
      long_phase  = 0;
    end
    take_s = (n > 1) && (short_phase == 0);
    take_l = (l > 1) && (long_phase == 0);
    y1 = (n <= 1 || take_s) ? longint'(x) : longint'(short_held);
    y2 = (l <= 1 || take_l) ? longint'(x) : longint'(long_held);
    // arithmetic shift floors the signed product
    blended = y1 + (((y2 - y1) * longint'(frac_q)) >>> FW);
    if (take_s) short_held = blended[SW-1:0];
    if (take_l) long_held = blended[SW-1:0];
    short_phase = (n <= 1 || short_phase + 1 >= n) ? 0 : short_phase + 1;
    long_phase  = (l <= 1 || long_phase + 1 >= l) ? 0 : long_phase + 1;
    return blended[SW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    logic signed [SW-1:0] want;
    if (!rst_ni) begin
      factor_q    = HOLD_FACTOR_RST;
      frac_q      = '0;
      short_phase = 0;
      long_phase  = 0;
      short_held  = '0;
      long_held   = '0;
      held_samples_due.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_HOLD_FACTOR: factor_q = cfg_data_i[HF_BITS-1:0];
          REG_HOLD_FRAC:   frac_q = cfg_data_i[FW-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        seen++;
        if (held_samples_due.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none, got %0d", $time, sample_out_i);
        end else begin
          want = held_samples_due.pop_front();
          if (sample_out_i !== want) begin
            mismatches++;
            $display("%0t: sample_out mismatch, expected %0d, got %0d",
                     $time, want, sample_out_i);
          end
        end
      end
      if (in_valid_i && in_ready_i)
        held_samples_due.push_back(hold_and_blend(sample_in_i, block_start_i));
    end
    pending_words <= held_samples_due.size();
    error_count   <= mismatches;
    checked_words <= seen;
  end

endmodule

[bench/tb_fractional_sample_hold_downsampler_unit.sv]
module tb_fractional_sample_hold_downsampler_unit;
  import fshd_pkg::*;

  localparam int     SW           = SAMPLE_BITS_DEF;
  localparam int     CFG_DW       = (FRAC_BITS_DEF > HF_BITS) ? FRAC_BITS_DEF : HF_BITS;
  localparam int     PERIOD       = 12;
  localparam int     MAX_GAP      = 14;
  localparam int     RANDOM_WORDS = 1350;
  localparam int     FRAC_MAX     = 65535;
  localparam longint RUN_LIMIT    = longint'(PERIOD) * 500000;

  localparam logic signed [SW-1:0] SAMPLE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAMPLE_MIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0] SAMPLE_NEG1 = '1;
  localparam logic signed [SW-1:0] SAMPLE_ZERO = '0;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_valid_i   = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index_i   = REG_HOLD_FACTOR;
  logic [CFG_DW-1:0]       cfg_data_i    = '0;
  logic                    in_valid_i    = 1'b0;
  logic signed [SW-1:0]    sample_in_i   = '0;
  logic                    block_start_i = 1'b0;
  logic                    out_ready_i   = 1'b0;
  logic                    cfg_ready_o;
  logic                    in_ready_o;
  logic                    out_valid_o;
  logic signed [SW-1:0]    sample_out_o;

  int error_count;
  int pending_words;
  int checked_words;
  int words_sent    = 0;
  int starts_sent   = 0;
  int settings_used = 0;
  bit quiet         = 1'b0;  // both sides back-to-back

  always #(PERIOD / 2) clk_i = ~clk_i;

  fractional_sample_hold_downsampler_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .block_start_i(block_start_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_o (sample_out_o)
  );

  fshd_hold_checker #(.CFG_DW(CFG_DW)) u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .sample_in_i  (sample_in_i),
    .block_start_i(block_start_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .sample_out_i (sample_out_o),
    .error_count  (error_count),
    .pending_words(pending_words),
    .checked_words(checked_words)
  );

  task automatic push_word(input logic signed [SW-1:0] s, input logic st);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    sample_in_i   <= s;
    block_start_i <= st;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    if (st) starts_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_hold(input int factor, input int frac);
    write_reg(REG_HOLD_FACTOR, CFG_DW'(factor));
    write_reg(REG_HOLD_FRAC, CFG_DW'(frac));
    cfg_valid_i <= 1'b0;
    settings_used++;
  endtask

  // wait for every word in flight, then let the pipeline idle before returning
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic signed [SW-1:0] draw_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return SAMPLE_ZERO;
      3: return SAMPLE_NEG1;
      default: return SW'($urandom());
    endcase
  endfunction

  // One setting, then blocks that mostly open with a start flag; a missing
  // start lets the phases run on from the previous setting.
  task automatic random_setting();
    int   factor;
    int   frac;
    int   eff;
    int   len;
    int   budget;
    logic st;
    case ($urandom_range(0, 9))
      0: factor = 0;
      1: factor = 1;
      2, 3, 4, 5: factor = $urandom_range(2, 8);
      6: factor = $urandom_range(9, MAX_HOLD_DEF);
      7: factor = MAX_HOLD_DEF;
      8: factor = $urandom_range(MAX_HOLD_DEF + 1, 127);
      default: factor = $urandom_range(0, 127);
    endcase
    case ($urandom_range(0, 3))
      0: frac = 0;
      1: frac = FRAC_MAX;
      default: frac = $urandom_range(0, FRAC_MAX);
    endcase
    quiet = ($urandom_range(0, 3) == 0);
    set_hold(factor, frac);
    eff    = (factor > MAX_HOLD_DEF) ? MAX_HOLD_DEF : factor;
    budget = $urandom_range(30, 90);
    while (budget > 0) begin
      len = $urandom_range(1, 3 * (eff + 1) + 2);
      for (int i = 0; i < len && budget > 0; i++) begin
        st = (i == 0) ? ($urandom_range(0, 4) != 0) : ($urandom_range(0, 15) == 0);
        push_word(draw_sample(), st);
        budget--;
      end
    end
    drain();
  endtask

  initial begin : sink
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings, phases counting from reset before any start
    push_word(SAMPLE_MAX, 1'b0);
    push_word(SAMPLE_MIN, 1'b0);
    push_word(SAMPLE_ZERO, 1'b0);
    push_word(SAMPLE_NEG1, 1'b0);
    push_word(SAMPLE_MAX, 1'b1);
    drain();

    // factor zero: both stages pass through
    set_hold(0, FRAC_MAX);
    push_word(SAMPLE_MIN, 1'b0);
    push_word(SAMPLE_MAX, 1'b1);
    drain();

    set_hold(2, FRAC_MAX);
    push_word(SAMPLE_MAX, 1'b1);
    push_word(SAMPLE_MIN, 1'b0);
    push_word(SAMPLE_MAX, 1'b0);
    push_word(SAMPLE_MIN, 1'b0);
    push_word(SAMPLE_NEG1, 1'b1);
    push_word(SAMPLE_ZERO, 1'b0);
    drain();

    // above the maximum: clamps
    set_hold(127, 32768);
    push_word(SAMPLE_MIN, 1'b1);
    push_word(SAMPLE_MAX, 1'b0);
    push_word(SAMPLE_MAX, 1'b0);
    push_word(SAMPLE_ZERO, 1'b0);
    drain();

    // smaller factor without a start: phases beyond the period wrap
    set_hold(3, 1);
    push_word(SAMPLE_MAX, 1'b0);
    push_word(SAMPLE_MIN, 1'b0);
    push_word(SAMPLE_MIN, 1'b1);
    push_word(SAMPLE_MAX, 1'b0);
    push_word(SAMPLE_MIN, 1'b0);
    drain();

    while (words_sent < RANDOM_WORDS + 22) random_setting();

    drain();
    $display("Checked %0d of %0d words over %0d hold settings with %0d block starts.",
             checked_words, words_sent, settings_used, starts_sent);
    $display("Factors 0 to 127 (clamped at %0d), fractions 0 to %0d, stalls and bursts.",
             MAX_HOLD_DEF, FRAC_MAX);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #(RUN_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/fshd_pkg.sv
hw/rtl/fshd_core.sv
hw/rtl/fractional_sample_hold_downsampler_unit.sv
bench/fshd_hold_checker.sv
bench/tb_fractional_sample_hold_downsampler_unit.sv
